@@ hw/rtl/gradient_color_sampler_macros.svh @@
// ----------------------------------------------------------------------------
// Gradient color sampler assertion macros
// Shared concurrent assertion forms used by the sampler's checker.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_SAMPLER_MACROS_SVH
`define GRADIENT_COLOR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define GCS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/gcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient color sampler package
// Widths, register indexes and types shared by the sampler files.
// ----------------------------------------------------------------------------
package gcs_pkg;

   // Position is signed Q2.16.
   localparam int POS_W   = 19;
   localparam int FRAC_W  = 16;

   // Color packing: four 8-bit channels, red in the low byte.
   localparam int CHAN_W   = 8;
   localparam int CHANNELS = 4;
   localparam int COLOR_W  = CHAN_W * CHANNELS;

   // Stop storage and the limit on stops in use.
   localparam int STOP_REGS  = 4;
   localparam int MAX_STOPS  = 4;
   localparam int STOP_LIMIT = (STOP_REGS < MAX_STOPS) ? STOP_REGS : MAX_STOPS;
   localparam int COUNT_W    = 3;
   localparam int IDX_W      = $clog2(STOP_REGS);

   // Scaled position: 16-bit fraction times the last stop index.
   localparam int SCALED_W = FRAC_W + IDX_W;

   // Blend arithmetic widths.
   localparam int DIFF_W = CHAN_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W;
   localparam int ACC_W  = PROD_W + 1;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COLOR_W;

   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COLOR_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COLOR_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COLOR_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COLOR_3 = 3'd4;

   // How a request's color is formed.
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_FIRST,
      KIND_LAST,
      KIND_BLEND
   } kind_type;

   typedef logic [COLOR_W-1:0] color_type;

endpackage

@@ hw/rtl/gcs_channel_if.sv @@
// ----------------------------------------------------------------------------
// Gradient color sampler channels
// Valid/ready interfaces for the position request and the color response.
// ----------------------------------------------------------------------------

// Request channel: one gradient position.
interface gcs_req_if;
   import gcs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink (input valid, input position, output ready);
endinterface

// Response channel: one RGBA color.
interface gcs_rsp_if;
   import gcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [CHAN_W-1:0] alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

@@ hw/rtl/gradient_color_sampler.sv @@
// Throughput: one request per cycle while rsp is ready; the four pipeline stages each
// hold one request. A stalled response holds the pipeline back stage by stage, bubbles
// are squeezed out. Reset clears all pipeline valid bits and sets stop_count and every
// stop color to zero.
// ----------------------------------------------------------------------------
// Gradient color sampler
// Interpolates an RGBA color between evenly spaced color stops for a Q2.16
// position, in four register stages: classify and scale, stop select,
// channel multiply, round and output.
// ----------------------------------------------------------------------------
module gradient_color_sampler #(
   parameter int MAX_STOPS = gcs_pkg::MAX_STOPS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [gcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   gcs_req_if.sink                        req,
   gcs_rsp_if.source                      rsp
);
   import gcs_pkg::*;

   localparam logic [ACC_W-1:0] HALF_Q16 = ACC_W'(1) << (FRAC_W - 1);

   // Stops in use never exceed the stop registers or the stop limit.
   localparam int STOP_USED_MAX = (STOP_REGS < MAX_STOPS) ? STOP_REGS : MAX_STOPS;

   // Configuration registers.
   logic [COUNT_W-1:0] stop_count_ff;
   color_type          stop_color_ff [STOP_REGS];

   // Stage valid bits and per-stage advance.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: classification and scaled position.
   kind_type              kind1_in, kind1_ff;
   logic [SCALED_W-1:0]   scaled1_in, scaled1_ff;
   logic [IDX_W-1:0]      last1_in, last1_ff;
   logic [COUNT_W-1:0]    n_eff;

   // Stage 2: end colors and fraction.
   color_type             col_a2_in, col_a2_ff;
   color_type             col_b2_in, col_b2_ff;
   logic [FRAC_W-1:0]     frac2_in, frac2_ff;
   logic [IDX_W-1:0]      seg;

   // Stage 3: start channel and weighted difference per lane.
   logic [CHAN_W-1:0]        ca3_in [CHANNELS];
   logic [CHAN_W-1:0]        ca3_ff [CHANNELS];
   logic signed [PROD_W-1:0] prod3_in [CHANNELS];
   logic signed [PROD_W-1:0] prod3_ff [CHANNELS];

   // Stage 4: rounded output color.
   color_type             out4_in, out4_ff;

   // Configuration write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         for (int i = 0; i < STOP_REGS; i++) begin
            stop_color_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            REG_STOP_COUNT:   stop_count_ff    <= csr_wdata[COUNT_W-1:0];
            REG_STOP_COLOR_0: stop_color_ff[0] <= csr_wdata;
            REG_STOP_COLOR_1: stop_color_ff[1] <= csr_wdata;
            REG_STOP_COLOR_2: stop_color_ff[2] <= csr_wdata;
            REG_STOP_COLOR_3: stop_color_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Each stage moves when it is empty or the stage after it moves.
   assign rdy4      = !v4_ff || rsp.ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req.valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // Stage 1: clamp the stop count, classify the position and scale it.
   always_comb begin
      n_eff = (stop_count_ff > COUNT_W'(STOP_USED_MAX)) ? COUNT_W'(STOP_USED_MAX)
                                                         : stop_count_ff;
      last1_in = IDX_W'(n_eff - COUNT_W'(1));
      if (n_eff == '0) begin
         kind1_in = KIND_ZERO;
      end else if (n_eff == COUNT_W'(1) || req.position[POS_W-1] || req.position == '0) begin
         kind1_in = KIND_FIRST;
      end else if (req.position[POS_W-2:FRAC_W] != '0) begin
         kind1_in = KIND_LAST;
      end else begin
         kind1_in = KIND_BLEND;
      end
      scaled1_in = SCALED_W'(req.position[FRAC_W-1:0]) * SCALED_W'(last1_in);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         kind1_ff   <= kind1_in;
         scaled1_ff <= scaled1_in;
         last1_ff   <= last1_in;
      end
   end

   // Stage 2: pick the two stop colors; fixed colors use a zero fraction.
   always_comb begin
      seg       = scaled1_ff[SCALED_W-1:FRAC_W];
      col_a2_in = '0;
      col_b2_in = '0;
      frac2_in  = '0;
      case (kind1_ff)
         KIND_ZERO: begin
            col_a2_in = '0;
         end
         KIND_FIRST: begin
            col_a2_in = stop_color_ff[0];
            col_b2_in = stop_color_ff[0];
         end
         KIND_LAST: begin
            col_a2_in = stop_color_ff[last1_ff];
            col_b2_in = stop_color_ff[last1_ff];
         end
         default: begin
            // A segment at or past the last stop falls back to the last stop.
            if (seg >= last1_ff) begin
               col_a2_in = stop_color_ff[last1_ff];
               col_b2_in = stop_color_ff[last1_ff];
            end else begin
               col_a2_in = stop_color_ff[seg];
               col_b2_in = stop_color_ff[seg + IDX_W'(1)];
               frac2_in  = scaled1_ff[FRAC_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         col_a2_ff <= col_a2_in;
         col_b2_ff <= col_b2_in;
         frac2_ff  <= frac2_in;
      end
   end

   // Stage 3: per channel, (b - a) times the fraction, both widened to the product.
   always_comb begin
      logic signed [DIFF_W-1:0] diff;
      for (int k = 0; k < CHANNELS; k++) begin
         ca3_in[k]   = col_a2_ff[k*CHAN_W +: CHAN_W];
         diff        = $signed({1'b0, col_b2_ff[k*CHAN_W +: CHAN_W]})
                     - $signed({1'b0, col_a2_ff[k*CHAN_W +: CHAN_W]});
         prod3_in[k] = PROD_W'(diff) * PROD_W'($signed({1'b0, frac2_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         for (int k = 0; k < CHANNELS; k++) begin
            ca3_ff[k]   <= ca3_in[k];
            prod3_ff[k] <= prod3_in[k];
         end
      end
   end

   // Stage 4: a * 65536 + product + half, then keep the integer byte.
   always_comb begin
      logic [ACC_W-1:0] acc;
      for (int k = 0; k < CHANNELS; k++) begin
         acc = {{(ACC_W - CHAN_W - FRAC_W){1'b0}}, ca3_ff[k], {FRAC_W{1'b0}}}
             + {prod3_ff[k][PROD_W-1], prod3_ff[k]}
             + HALF_Q16;
         out4_in[k*CHAN_W +: CHAN_W] = acc[FRAC_W +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out4_ff <= out4_in;
      end
   end

   // Response drive.
   assign rsp.valid = v4_ff;
   assign rsp.red   = out4_ff[0*CHAN_W +: CHAN_W];
   assign rsp.green = out4_ff[1*CHAN_W +: CHAN_W];
   assign rsp.blue  = out4_ff[2*CHAN_W +: CHAN_W];
   assign rsp.alpha = out4_ff[3*CHAN_W +: CHAN_W];

endmodule

@@ hw/rtl/gcs_checker.sv @@
// ----------------------------------------------------------------------------
// Gradient color sampler checker
// Port-level checks of flow control and pipeline latency, bound to the top.
// ----------------------------------------------------------------------------
`include "gradient_color_sampler_macros.svh"

module gcs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [gcs_pkg::CHAN_W-1:0] rsp_red,
   input logic [gcs_pkg::CHAN_W-1:0] rsp_green,
   input logic [gcs_pkg::CHAN_W-1:0] rsp_blue,
   input logic [gcs_pkg::CHAN_W-1:0] rsp_alpha
);
   import gcs_pkg::*;

   // A stalled response keeps its color.
   `GCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha), "stalled response changed")

   // Reset empties the pipeline.
   `GCS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response valid after reset")

   // With the output free, a new request is always taken.
   `GCS_ASSERT_IMPL(a_no_stall, clock, reset, !rsp_valid || rsp_ready, req_ready, "request refused while output free")

   // An accepted request shows up as a valid response when the output keeps flowing.
   `GCS_ASSERT_IMPL(a_latency, clock, reset, $past(req_valid && req_ready, 4) && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3) && !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4), rsp_valid, "response missing after four cycles")

endmodule

bind gradient_color_sampler gcs_checker u_gcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_red   (rsp.red),
   .rsp_green (rsp.green),
   .rsp_blue  (rsp.blue),
   .rsp_alpha (rsp.alpha)
);
